// ----- hdl/bo3_pkg.sv -----
`default_nettype none

package bo3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int CFG_W     = 16;
    localparam int ROWCNT_W  = FH_W + 1;
    localparam int ROW_W     = FH_W + 2;
    localparam int MIN_DIM   = 3;

    typedef logic [7:0]              pixel_t;
    typedef logic [COL_W-1:0]        col_t;
    typedef logic [WCNT_W-1:0]       wcnt_t;
    typedef logic [FH_W-1:0]         hcnt_t;
    typedef logic [ROWCNT_W-1:0]     rowcnt_t;
    typedef logic signed [ROW_W-1:0] row_t;
    typedef logic [0:0]              reg_index_t;

    localparam reg_index_t REG_FRAME_WIDTH  = 1'b0;
    localparam reg_index_t REG_FRAME_HEIGHT = 1'b1;

    localparam pixel_t PIX_LOW  = 8'd0;
    localparam pixel_t PIX_HIGH = 8'd255;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    typedef struct packed {
        wcnt_t width;
        hcnt_t height;
    } geom_t;

    typedef struct packed {
        logic   valid;
        pixel_t pixel;
        row_t   row;
        col_t   col;
    } item_t;

endpackage

`default_nettype wire

// ----- hdl/bo3_stage.sv -----
`default_nettype none

module bo3_stage
    import bo3_pkg::*;
(
    input  wire    clk,
    input  wire    rst_n,
    input  wire    adv,
    input  geom_t  geom,
    input  pixel_t active_level,
    input  item_t  entry,
    output item_t  leave,
    output pixel_t centre
);

    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] rd_reg;
    logic        hold_valid_reg;
    pixel_t      hold_pixel_reg;
    row_t        hold_row_reg;
    col_t        hold_col_reg;
    pixel_t      win_reg [9];
    pixel_t      win_next [9];

    pixel_t      top;
    pixel_t      mid;
    logic        has_other;
    logic        interior;
    row_t        back_row;
    col_t        back_col;
    wcnt_t       width_m1;
    row_t        height_m2;
    logic        fwd;

    always_comb
    begin
        top = rd_reg[15:8];
        mid = rd_reg[7:0];
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3+1];
            win_next[i*3+1]   = win_reg[i*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = hold_pixel_reg;

        has_other = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            if (win_next[i] == ~active_level)
            begin
                has_other = 1'b1;
            end
        end

        width_m1 = geom.width - WCNT_W'(1);
        if (hold_col_reg != '0)
        begin
            back_row = hold_row_reg - row_t'(1);
            back_col = hold_col_reg - col_t'(1);
        end
        else
        begin
            back_row = hold_row_reg - row_t'(2);
            back_col = width_m1[COL_W-1:0];
        end

        height_m2 = row_t'(geom.height) - row_t'(2);
        interior  = (back_row >= row_t'(1)) && (back_row <= height_m2)
                    && (back_col != '0) && (WCNT_W'(back_col) <= geom.width - WCNT_W'(2));

        centre = win_next[4];

        leave.valid = hold_valid_reg;
        leave.pixel = (interior && (win_next[4] == active_level) && has_other)
                      ? ~active_level : win_next[4];
        leave.row   = back_row;
        leave.col   = back_col;

        fwd = hold_valid_reg && (entry.col == hold_col_reg);
    end

    // read for the entering item, forward the word being written by the held one
    always_ff @(posedge clk)
    begin
        if (adv && hold_valid_reg)
        begin
            line_mem[hold_col_reg] <= {mid, hold_pixel_reg};
        end
        if (adv && entry.valid)
        begin
            if (fwd)
            begin
                rd_reg <= {mid, hold_pixel_reg};
            end
            else
            begin
                rd_reg <= line_mem[entry.col];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= PIX_LOW;
            end
        end
        else if (adv)
        begin
            hold_valid_reg <= entry.valid;
            if (hold_valid_reg)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && entry.valid)
        begin
            hold_pixel_reg <= entry.pixel;
            hold_row_reg   <= entry.row;
            hold_col_reg   <= entry.col;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/binary_open_3x3.sv -----
`default_nettype none

// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  pixel_in, frame_start, flush
// output   out        out_valid/ out_stall eroded_pixel, opened_pixel, frame_last
// config   in         cfg_wr_en            cfg_index, cfg_data
//
// One item accepted per clock while in_stall is low; two line-buffer stages and a
// result register lie between acceptance and result.
// The result for a pixel comes out on the item 2*frame_width+2 places later.
// Reset clears the counters, windows and valid flags; line buffers are not cleared.
// out_stall with a waiting result freezes every stage and raises in_stall.

module binary_open_3x3
    import bo3_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [7:0]         pixel_in,
    input  wire                frame_start,
    input  wire                flush,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         eroded_pixel,
    output logic [7:0]         opened_pixel,
    output logic               frame_last,
    input  wire                cfg_wr_en,
    input  wire  [0:0]         cfg_index,
    input  wire  [CFG_W-1:0]   cfg_data
);

    geom_t   geom;
    wcnt_t   width_reg;
    hcnt_t   height_reg;
    col_t    col_reg;
    col_t    col_next;
    rowcnt_t row_reg;
    rowcnt_t row_next;
    col_t    c0;
    rowcnt_t r0;
    wcnt_t   col_inc;
    logic    accept;
    logic    adv;
    item_t   entry;
    item_t   eroded_item;
    item_t   opened_item;
    pixel_t  centre_in;
    pixel_t  centre_er;
    logic    in_frame;
    logic    last;

    logic    res_valid_reg;
    pixel_t  res_eroded_reg;
    pixel_t  res_opened_reg;
    logic    res_last_reg;

    function automatic wcnt_t clamp_width(input logic [FW_W-1:0] v);
        wcnt_t r;
        if (int'(v) < MIN_DIM)
        begin
            r = WCNT_W'(MIN_DIM);
        end
        else if (int'(v) > MAX_WIDTH)
        begin
            r = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            r = WCNT_W'(v);
        end
        return r;
    endfunction

    function automatic hcnt_t clamp_height(input logic [FH_W-1:0] v);
        hcnt_t r;
        if (v < FH_W'(MIN_DIM))
        begin
            r = FH_W'(MIN_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WCNT_W'(FRAME_WIDTH_RESET);
            height_reg <= FH_W'(FRAME_HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= clamp_width(cfg_data[FW_W-1:0]);
                REG_FRAME_HEIGHT: height_reg <= clamp_height(cfg_data[FH_W-1:0]);
            endcase
        end
    end

    assign geom = {width_reg, height_reg};

    assign in_stall = res_valid_reg && out_stall;
    assign adv      = !in_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (!flush && frame_start)
        begin
            c0 = '0;
            r0 = '0;
        end
        else
        begin
            c0 = col_reg;
            r0 = row_reg;
        end

        col_inc = WCNT_W'(c0) + WCNT_W'(1);
        if (col_inc >= width_reg)
        begin
            col_next = '0;
            if (r0 < ROWCNT_W'(height_reg) + ROWCNT_W'(3))
            begin
                row_next = r0 + ROWCNT_W'(1);
            end
            else
            begin
                row_next = r0;
            end
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = r0;
        end

        entry.valid = accept;
        entry.pixel = flush ? PIX_LOW : pixel_in;
        entry.row   = row_t'(r0);
        entry.col   = c0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    bo3_stage u_erode (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .geom         (geom),
        .active_level (PIX_HIGH),
        .entry        (entry),
        .leave        (eroded_item),
        .centre       (centre_in)
    );

    bo3_stage u_dilate (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .geom         (geom),
        .active_level (PIX_LOW),
        .entry        (eroded_item),
        .leave        (opened_item),
        .centre       (centre_er)
    );

    always_comb
    begin
        in_frame = !opened_item.row[ROW_W-1]
                   && (opened_item.row < row_t'(height_reg))
                   && (WCNT_W'(opened_item.col) < width_reg);
        last     = (opened_item.row == row_t'(height_reg) - row_t'(1))
                   && (WCNT_W'(opened_item.col) == width_reg - WCNT_W'(1));
    end

    // drop positions outside the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= opened_item.valid && in_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_eroded_reg <= centre_er;
            res_opened_reg <= opened_item.pixel;
            res_last_reg   <= last;
        end
    end

    assign out_valid    = res_valid_reg;
    assign eroded_pixel = res_eroded_reg;
    assign opened_pixel = res_opened_reg;
    assign frame_last   = res_last_reg;

    logic unused_centre;
    assign unused_centre = ^centre_in;

endmodule

`default_nettype wire

// ----- tb/tb_binary_open_3x3.sv -----
module tb_binary_open_3x3;
    import bo3_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_ITEMS    = 1050;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 40;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_PATTERN} stall_mode_t;

    typedef struct packed {
        pixel_t eroded;
        pixel_t opened;
        logic   last;
    } open_result_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic [7:0]       pixel_in    = 8'd0;
    logic             frame_start = 1'b0;
    logic             flush       = 1'b0;
    logic             out_stall   = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    reg_index_t       cfg_index   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_stall;
    logic             out_valid;
    logic [7:0]       eroded_pixel;
    logic [7:0]       opened_pixel;
    logic             frame_last;

    binary_open_3x3 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .frame_start  (frame_start),
        .flush        (flush),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .eroded_pixel (eroded_pixel),
        .opened_pixel (opened_pixel),
        .frame_last   (frame_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state: stage 0 is erosion, stage 1 is dilation
    pixel_t line_buf [2][2*MAX_WIDTH];
    pixel_t nbhd [2][9];
    int     col_in;
    int     row_in;
    int     cfg_width;
    int     cfg_height;

    open_result_t expected_px [$];
    open_result_t want_px;

    int items_sent     = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int frames_started = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int w_lo           = MAX_WIDTH;
    int w_hi           = 0;
    int h_lo           = 1 << FH_W;
    int h_hi           = 0;

    int          hold_len    = 0;
    int          hold_req_id = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          stall_phase = 0;
    stall_mode_t stall_mode  = STALL_NONE;

    function automatic void clear_predictor();
        int s;
        int i;
        for (s = 0; s < 2; s++)
        begin
            for (i = 0; i < 2*MAX_WIDTH; i++)
                line_buf[s][i] = PIX_LOW;
            for (i = 0; i < 9; i++)
                nbhd[s][i] = PIX_LOW;
        end
        col_in     = 0;
        row_in     = 0;
        cfg_width  = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
    endfunction

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < MIN_DIM)
            w = MIN_DIM;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < MIN_DIM)
            h = MIN_DIM;
        return h;
    endfunction

    function automatic void push_column(input int s, input int col, input pixel_t v);
        int     i;
        int     r;
        pixel_t top;
        pixel_t mid;
        i   = col % MAX_WIDTH;
        top = line_buf[s][MAX_WIDTH + i];
        mid = line_buf[s][i];
        line_buf[s][MAX_WIDTH + i] = mid;
        line_buf[s][i]             = v;
        for (r = 0; r < 3; r++)
        begin
            nbhd[s][r*3]     = nbhd[s][r*3 + 1];
            nbhd[s][r*3 + 1] = nbhd[s][r*3 + 2];
        end
        nbhd[s][2] = top;
        nbhd[s][5] = mid;
        nbhd[s][8] = v;
    endfunction

    function automatic bit is_inner(input int r, input int c, input int w, input int h);
        return r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2;
    endfunction

    function automatic bit window_holds(input int s, input pixel_t v);
        int i;
        for (i = 0; i < 9; i++)
            if (nbhd[s][i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // one stage of delay is width+1 places back in raster order
    function automatic void step_back(input int r, input int c, input int w,
                                      output int ro, output int co);
        if (c >= 1)
        begin
            ro = r - 1;
            co = c - 1;
        end
        else
        begin
            ro = r - 2;
            co = w - 1;
        end
    endfunction

    function automatic void predict_open(input pixel_t raw, input bit start, input bit fl);
        int           w;
        int           h;
        int           c0;
        int           r0;
        int           c1;
        int           r1;
        int           c2;
        int           r2;
        pixel_t       pix;
        pixel_t       e;
        pixel_t       o;
        open_result_t res;
        w   = eff_width();
        h   = eff_height();
        pix = fl ? PIX_LOW : raw;
        if (!fl && start)
        begin
            col_in = 0;
            row_in = 0;
            frames_started++;
            if (w < w_lo) w_lo = w;
            if (w > w_hi) w_hi = w;
            if (h < h_lo) h_lo = h;
            if (h > h_hi) h_hi = h;
        end
        c0 = col_in % MAX_WIDTH;
        r0 = row_in;

        push_column(0, c0, pix);
        step_back(r0, c0, w, r1, c1);
        e = nbhd[0][4];
        if (is_inner(r1, c1, w, h) && e == PIX_HIGH && window_holds(0, PIX_LOW))
            e = PIX_LOW;
        c1 = c1 % MAX_WIDTH;

        push_column(1, c1, e);
        step_back(r1, c1, w, r2, c2);
        o = nbhd[1][4];
        if (is_inner(r2, c2, w, h) && o == PIX_LOW && window_holds(1, PIX_HIGH))
            o = PIX_HIGH;

        if (c0 + 1 >= w)
        begin
            col_in = 0;
            if (r0 < h + 3)
                row_in = r0 + 1;
        end
        else
            col_in = c0 + 1;

        if (r2 >= 0 && r2 < h && c2 < w)
        begin
            res.eroded = nbhd[1][4];
            res.opened = o;
            res.last   = (r2 == h - 1 && c2 == w - 1);
            expected_px.push_back(res);
        end
    endfunction

    function automatic pixel_t rand_level(input int density);
        if ($urandom_range(0, 99) < 5)
            return pixel_t'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < density)
            return PIX_HIGH;
        return PIX_LOW;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    task automatic send_item(input pixel_t p, input bit s, input bit f);
        bit taken;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(60, 240);
            else
                burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        burst_left--;
        in_valid    <= 1'b1;
        pixel_in    <= p;
        frame_start <= s;
        flush       <= f;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        predict_open(p, s, f);
        items_sent++;
    endtask

    task automatic send_frame(input int density, input int count, input bit sprinkle);
        int k;
        for (k = 0; k < count; k++)
            if (k > 0 && sprinkle && $urandom_range(0, 7) == 0)
                send_item(pixel_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else
                send_item(rand_level(density), k == 0, 1'b0);
    endtask

    task automatic send_flush(input int n);
        repeat (n) send_item(pixel_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            cfg_width = int'(val[FW_W-1:0]);
        else
            cfg_height = int'(val[FH_W-1:0]);
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
        settle();
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
    endtask

    task automatic test_directed();
        pixel_t pat [9];
        int     k;
        // both registers below the minimum: clamp to a 3x3 frame
        set_geometry(16'd0, 16'd1);
        pat = '{PIX_LOW, PIX_HIGH, PIX_HIGH, PIX_HIGH, PIX_HIGH, PIX_HIGH,
                8'd254, PIX_HIGH, 8'd1};
        for (k = 0; k < 9; k++)
            send_item(pat[k], k == 0, 1'b0);
        send_item(PIX_HIGH, 1'b1, 1'b1);
        send_flush(7);
        for (k = 0; k < 4; k++)
            send_item(PIX_HIGH, k == 0, 1'b0);
        pat = '{PIX_HIGH, PIX_HIGH, PIX_HIGH, PIX_HIGH, PIX_LOW, PIX_HIGH,
                PIX_HIGH, 8'd128, PIX_HIGH};
        for (k = 0; k < 9; k++)
            send_item(pat[k], k == 0, 1'b0);
        // run on past the end of the frame until the row count saturates
        repeat (12) send_item(PIX_HIGH, 1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_geometry(16'hFFFF, 16'h0000);
        send_frame(70, 64, 1'b0);
        set_geometry(16'd3, 16'hFFFF);
        send_frame(60, 3*12, 1'b0);
    endtask

    task automatic test_backpressure();
        set_geometry(16'd8, 16'd5);
        hold_len = 300;
        hold_req_id++;
        send_frame(80, 40, 1'b0);
        send_flush(18);
        settle();
        send_frame(80, 40, 1'b0);
        send_flush(18);
    endtask

    task automatic test_random_streams();
        int start_count;
        int w;
        int h;
        int tail;
        int density;
        int wv;
        int hv;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (items_sent == start_count || $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       wv = $urandom_range(0, 2);
                    1:       wv = $urandom_range(17, 40);
                    default: wv = $urandom_range(3, 16);
                endcase
                if ($urandom_range(0, 5) == 0)
                    wv = wv | ($urandom_range(1, 31) << FW_W);
                hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
                set_geometry(CFG_W'(wv), CFG_W'(hv));
            end
            w       = eff_width();
            h       = eff_height();
            density = $urandom_range(10, 95);
            if ($urandom_range(0, 24) == 0)
            begin
                hold_len = $urandom_range(40, 200);
                hold_req_id++;
            end
            if ($urandom_range(0, 9) < 9)
            begin
                send_frame(density, w*h, 1'b0);
                tail = $urandom_range(0, 9);
                if (tail < 7)
                    send_flush(2*w + 2);
                else if (tail == 8)
                    repeat ($urandom_range(1, 4*w)) send_item(rand_level(density), 1'b0, 1'b0);
            end
            else
                send_frame(density, $urandom_range(1, w*h - 1), 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_req_id)
        begin
            hold_seen = hold_req_id;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                stall_mode  = stall_mode_t'($urandom_range(0, 3));
                stall_phase = $urandom_range(16, 160);
            end
            stall_phase--;
            case (stall_mode)
                STALL_NONE:    out_stall <= 1'b0;
                STALL_SPARSE:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:    out_stall <= 1'($urandom_range(0, 1));
                STALL_PATTERN: out_stall <= ((stall_phase % 7) < 4);
            endcase
        end
    end

    // sample mid-cycle: these are the values the next rising edge accepts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_seen++;
                if (expected_px.size() == 0)
                    report_mismatch("result with nothing expected", 16'(opened_pixel), 16'd0);
                else
                begin
                    want_px = expected_px.pop_front();
                    if (eroded_pixel !== want_px.eroded)
                        report_mismatch("eroded_pixel", 16'(eroded_pixel),
                                        16'(want_px.eroded));
                    if (opened_pixel !== want_px.opened)
                        report_mismatch("opened_pixel", 16'(opened_pixel),
                                        16'(want_px.opened));
                    if (frame_last !== want_px.last)
                        report_mismatch("frame_last", 16'(frame_last), 16'(want_px.last));
                end
            end
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_px.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        clear_predictor();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_streams();
        settle();
        repeat (16) @(posedge clk);
        $display("Sent %0d items over %0d frames, widths %0d to %0d, heights %0d to %0d",
                 items_sent, frames_started, w_lo, w_hi, h_lo, h_hi);
        $display("Compared %0d opened pixels, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bo3_pkg.sv
hdl/bo3_stage.sv
hdl/binary_open_3x3.sv
tb/tb_binary_open_3x3.sv
